FILE: hw/rtl/bgsc_pkg.sv
// Package for the BLOSUM62 greedy sequence cluster block.
// Holds widths, state encoding and the BLOSUM62 substitution table.
// No dependencies.
package bgsc_pkg;

  localparam int unsigned DefMaxSequences = 256;
  localparam int unsigned DefMaxLength    = 32;

  localparam int unsigned RES_W   = 7;
  localparam int unsigned LABEL_W = 9;
  localparam int unsigned SCORE_W = 10;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned ROM_N   = 24;

  localparam logic [4:0]             ROM_NONE      = 5'd24;
  localparam logic [LABEL_W-1:0]     LABEL_MAX     = 9'd511;
  localparam logic signed [SCORE_W-1:0] THRESH_RESET = 10'sd20;
  localparam logic signed [SCORE_W-1:0] SCORE_HI     = 10'sd511;
  localparam logic signed [SCORE_W-1:0] SCORE_LO     = -10'sd512;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LEN,
    ST_RUN,
    ST_DRAIN,
    ST_CMP,
    ST_LBL,
    ST_FIN
  } bgsc_state_e;

  localparam logic signed [4:0] BLOSUM_ROM [576] = '{
     4,-1,-2,-2, 0,-1,-1, 0,-2,-1,-1,-1,-1,-2,-1, 1, 0,-3,-2, 0,-2,-1, 0,-4,
    -1, 5, 0,-2,-3, 1, 0,-2, 0,-3,-2, 2,-1,-3,-2,-1,-1,-3,-2,-3,-1, 0,-1,-4,
    -2, 0, 6, 1,-3, 0, 0, 0, 1,-3,-3, 0,-2,-3,-2, 1, 0,-4,-2,-3, 3, 0,-1,-4,
    -2,-2, 1, 6,-3, 0, 2,-1,-1,-3,-4,-1,-3,-3,-1, 0,-1,-4,-3,-3, 4, 1,-1,-4,
     0,-3,-3,-3, 9,-3,-4,-3,-3,-1,-1,-3,-1,-2,-3,-1,-1,-2,-2,-1,-3,-3,-2,-4,
    -1, 1, 0, 0,-3, 5, 2,-2, 0,-3,-2, 1, 0,-3,-1, 0,-1,-2,-1,-2, 0, 3,-1,-4,
    -1, 0, 0, 2,-4, 2, 5,-2, 0,-3,-3, 1,-2,-3,-1, 0,-1,-3,-2,-2, 1, 4,-1,-4,
     0,-2, 0,-1,-3,-2,-2, 6,-2,-4,-4,-2,-3,-3,-2, 0,-2,-2,-3,-3,-1,-2,-1,-4,
    -2, 0, 1,-1,-3, 0, 0,-2, 8,-3,-3,-1,-2,-1,-2,-1,-2,-2, 2,-3, 0, 0,-1,-4,
    -1,-3,-3,-3,-1,-3,-3,-4,-3, 4, 2,-3, 1, 0,-3,-2,-1,-3,-1, 3,-3,-3,-1,-4,
    -1,-2,-3,-4,-1,-2,-3,-4,-3, 2, 4,-2, 2, 0,-3,-2,-1,-2,-1, 1,-4,-3,-1,-4,
    -1, 2, 0,-1,-3, 1, 1,-2,-1,-3,-2, 5,-1,-3,-1, 0,-1,-3,-2,-2, 0, 1,-1,-4,
    -1,-1,-2,-3,-1, 0,-2,-3,-2, 1, 2,-1, 5, 0,-2,-1,-1,-1,-1, 1,-3,-1,-1,-4,
    -2,-3,-3,-3,-2,-3,-3,-3,-1, 0, 0,-3, 0, 6,-4,-2,-2, 1, 3,-1,-3,-3,-1,-4,
    -1,-2,-2,-1,-3,-1,-1,-2,-2,-3,-3,-1,-2,-4, 7,-1,-1,-4,-3,-2,-2,-1,-2,-4,
     1,-1, 1, 0,-1, 0, 0, 0,-1,-2,-2, 0,-1,-2,-1, 4, 1,-3,-2,-2, 0, 0, 0,-4,
     0,-1, 0,-1,-1,-1,-1,-2,-2,-1,-1,-1,-1,-2,-1, 1, 5,-2,-2, 0,-1,-1, 0,-4,
    -3,-3,-4,-4,-2,-2,-3,-2,-2,-3,-2,-3,-1, 1,-4,-3,-2,11, 2,-3,-4,-3,-2,-4,
    -2,-2,-2,-3,-2,-1,-2,-3, 2,-1,-1,-2,-1, 3,-3,-2,-2, 2, 7,-1,-3,-2,-1,-4,
     0,-3,-3,-3,-1,-2,-2,-3,-3, 3, 1,-2, 1,-1,-2,-2, 0,-3,-1, 4,-3,-2,-1,-4,
    -2,-1, 3, 4,-3, 0, 1,-1, 0,-3,-4, 0,-3,-3,-2, 0,-1,-4,-3,-3, 4, 1,-1,-4,
    -1, 0, 0, 1,-3, 3, 4,-2, 0,-3,-3, 1,-1,-3,-1, 0,-1,-3,-2,-2, 1, 4,-1,-4,
     0,-1,-1,-1,-2,-1,-1,-1,-1,-1,-1,-1,-1,-1,-2, 0, 0,-2,-1,-1,-1,-1,-1,-4,
    -4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4,-4, 1
  };

  // Map an ASCII code to its table row; uppercase only.
  function automatic logic [4:0] rom_index(input logic [RES_W-1:0] c);
    logic [4:0] r;
    case (c)
      7'd65:   r = 5'd0;
      7'd82:   r = 5'd1;
      7'd78:   r = 5'd2;
      7'd68:   r = 5'd3;
      7'd67:   r = 5'd4;
      7'd81:   r = 5'd5;
      7'd69:   r = 5'd6;
      7'd71:   r = 5'd7;
      7'd72:   r = 5'd8;
      7'd73:   r = 5'd9;
      7'd76:   r = 5'd10;
      7'd75:   r = 5'd11;
      7'd77:   r = 5'd12;
      7'd70:   r = 5'd13;
      7'd80:   r = 5'd14;
      7'd83:   r = 5'd15;
      7'd84:   r = 5'd16;
      7'd87:   r = 5'd17;
      7'd89:   r = 5'd18;
      7'd86:   r = 5'd19;
      7'd66:   r = 5'd20;
      7'd90:   r = 5'd21;
      7'd88:   r = 5'd22;
      7'd42:   r = 5'd23;
      default: r = ROM_NONE;
    endcase
    return r;
  endfunction

  // Substitution value of two residues; unknown letters score zero.
  function automatic logic signed [4:0] pair_value(input logic [RES_W-1:0] a,
                                                   input logic [RES_W-1:0] b);
    logic [4:0] ia;
    logic [4:0] ib;
    logic [9:0] addr;
    ia = rom_index(a);
    ib = rom_index(b);
    addr = 10'(ia) * 10'(ROM_N) + 10'(ib);
    if (ia == ROM_NONE || ib == ROM_NONE) return 5'sd0;
    return BLOSUM_ROM[addr];
  endfunction

  function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [SUM_W-1:0] s);
    if (s > SUM_W'(SCORE_HI)) return SCORE_HI;
    if (s < SUM_W'(SCORE_LO)) return SCORE_LO;
    return s[SCORE_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/bgsc_stream_if.sv
// Valid/ready channel interfaces for the sequence cluster block.
// Depends on bgsc_pkg for field widths.
interface bgsc_res_if import bgsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] residue;
  logic             last_residue;
  logic             first_of_set;
  modport source (output valid, residue, last_residue, first_of_set, input ready);
  modport sink   (input valid, residue, last_residue, first_of_set, output ready);
endinterface

interface bgsc_out_if import bgsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [LABEL_W-1:0]        cluster_label;
  logic signed [SCORE_W-1:0] best_score;
  logic [INDEX_W-1:0]        best_index;
  logic                      had_match;
  logic                      store_full;
  logic                      truncated;
  modport source (output valid, cluster_label, best_score, best_index, had_match,
                  store_full, truncated, input ready);
  modport sink   (input valid, cluster_label, best_score, best_index, had_match,
                  store_full, truncated, output ready);
endinterface

FILE: hw/rtl/blosum_greedy_sequence_cluster.sv
// Greedy leader clustering of protein sequences under BLOSUM62.
// Depends on bgsc_pkg and the channel interfaces in bgsc_stream_if.
//
// Usage:
//   in_i carries one residue beat at a time (ASCII letter, last_residue,
//   first_of_set). first_of_set starts a new set and drops all stored
//   sequences and clusters. out_o carries one result beat per finished
//   sequence (the beat with last_residue set).
//   cfg_we_i/cfg_wdata_i write the signed join threshold; write it while idle.
// Timing:
//   A residue beat that does not end a sequence leaves the block idle and
//   ready for the next beat. An ending beat starts a walk in which one shared
//   lookup-and-add unit walks the first min(len, len_k) residues of every
//   stored sequence k out of the sequence memory, one residue per cycle.
//   in_i.ready is low during that walk.
// Reset:
//   Clears counters, flags and the threshold (to 20); memories are not
//   cleared, only entries written in the current set are ever read.
// Stall:
//   A result waits in the output register; the next sequence can stream in
//   meanwhile, and only the final step of the following result holds until
//   out_o is free.
module blosum_greedy_sequence_cluster import bgsc_pkg::*; #(
  parameter int unsigned MAX_SEQUENCES = DefMaxSequences,
  parameter int unsigned MAX_LENGTH    = DefMaxLength
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic signed [SCORE_W-1:0] cfg_wdata_i,
  bgsc_res_if.sink                  in_i,
  bgsc_out_if.source                out_o
);

  localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int unsigned IW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SEQUENCES + 1);
  localparam int unsigned KW    = $clog2(MAX_SEQUENCES);
  localparam int unsigned SDEPTH = MAX_SEQUENCES * MAX_LENGTH;
  localparam int unsigned SA_W  = $clog2(SDEPTH);

  // Memories: sequence residues, lengths, labels, current sequence.
  logic [RES_W-1:0]   seq_mem [SDEPTH];
  logic [LEN_W-1:0]   len_mem [MAX_SEQUENCES];
  logic [LABEL_W-1:0] lbl_mem [MAX_SEQUENCES];
  logic [RES_W-1:0]   cur_mem [MAX_LENGTH];

  bgsc_state_e state_q, state_d;

  logic signed [SCORE_W-1:0] thresh_q;
  logic [LEN_W-1:0]   cur_len_q, cur_len_d;
  logic               trunc_q, trunc_d;
  logic [CNT_W-1:0]   stored_q, stored_d;
  logic [SA_W-1:0]    base_q, base_d;
  logic [LABEL_W-1:0] clus_q, clus_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [SA_W-1:0]    kbase_q, kbase_d;
  logic [LEN_W-1:0]   n_q, n_d;
  logic [LEN_W-1:0]   i_q, i_d;
  logic               pend_q, pend_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic signed [SCORE_W-1:0] best_q, best_d;
  logic [CNT_W-1:0]   bestk_q, bestk_d;
  logic               have_q, have_d;

  logic               out_valid_q, out_valid_d;
  logic [LABEL_W-1:0] out_label_q, out_label_d;
  logic signed [SCORE_W-1:0] out_score_q, out_score_d;
  logic [INDEX_W-1:0] out_index_q, out_index_d;
  logic               out_match_q, out_match_d;
  logic               out_full_q, out_full_d;
  logic               out_trunc_q, out_trunc_d;

  logic [RES_W-1:0]   seq_rd_q, cur_rd_q;
  logic [LEN_W-1:0]   len_rd_q;
  logic [LABEL_W-1:0] lbl_rd_q;

  // Write strobes.
  logic               cur_we, seq_we, meta_we;
  logic [SA_W-1:0]    seq_wa;
  logic [LEN_W-1:0]   eff_len;
  logic [CNT_W-1:0]   eff_cnt;
  logic [SA_W-1:0]    eff_base;
  logic [LABEL_W-1:0] new_label;
  logic [LABEL_W-1:0] fin_label;
  logic               fin_match;
  logic signed [SCORE_W-1:0] cmp_score;
  logic [31:0]        bestk_wide;

  assign in_i.ready = (state_q == ST_IDLE);

  // A set start drops everything before this beat is taken.
  assign eff_len  = in_i.first_of_set ? '0 : cur_len_q;
  assign eff_cnt  = in_i.first_of_set ? '0 : stored_q;
  assign eff_base = in_i.first_of_set ? '0 : base_q;
  assign seq_wa   = eff_base + SA_W'(eff_len);

  assign cmp_score  = sat_score(sum_q);
  assign fin_match  = have_q && (best_q > thresh_q);
  assign new_label  = (clus_q == LABEL_MAX) ? LABEL_MAX : clus_q + 1'b1;
  assign fin_label  = fin_match ? lbl_rd_q : new_label;
  assign bestk_wide = 32'(bestk_q);

  always_comb begin
    state_d     = state_q;
    cur_len_d   = cur_len_q;
    trunc_d     = trunc_q;
    stored_d    = stored_q;
    base_d      = base_q;
    clus_d      = clus_q;
    k_d         = k_q;
    kbase_d     = kbase_q;
    n_d         = n_q;
    i_d         = i_q;
    pend_d      = 1'b0;
    sum_d       = sum_q;
    best_d      = best_q;
    bestk_d     = bestk_q;
    have_d      = have_q;
    cur_we      = 1'b0;
    seq_we      = 1'b0;
    meta_we     = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_label_d = out_label_q;
    out_score_d = out_score_q;
    out_index_d = out_index_q;
    out_match_d = out_match_q;
    out_full_d  = out_full_q;
    out_trunc_d = out_trunc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          stored_d = eff_cnt;
          base_d   = eff_base;
          clus_d   = in_i.first_of_set ? '0 : clus_q;
          trunc_d  = in_i.first_of_set ? 1'b0 : trunc_q;
          if (eff_len < LEN_W'(MAX_LENGTH)) begin
            cur_we    = 1'b1;
            seq_we    = (eff_cnt < CNT_W'(MAX_SEQUENCES));
            cur_len_d = eff_len + 1'b1;
          end else begin
            cur_len_d = eff_len;
            trunc_d   = 1'b1;
          end
          if (in_i.last_residue) begin
            k_d     = '0;
            kbase_d = '0;
            have_d  = 1'b0;
            best_d  = '0;
            bestk_d = '0;
            state_d = (eff_cnt == '0) ? ST_LBL : ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        // Length read of sequence k is in flight.
        state_d = ST_LEN;
      end
      ST_LEN: begin
        n_d     = (len_rd_q < cur_len_q) ? len_rd_q : cur_len_q;
        i_d     = '0;
        sum_d   = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        pend_d = 1'b1;
        i_d    = i_q + 1'b1;
        if (i_q + 1'b1 == n_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!have_q || cmp_score > best_q) begin
          best_d  = cmp_score;
          bestk_d = k_q;
          have_d  = 1'b1;
        end
        k_d     = k_q + 1'b1;
        kbase_d = kbase_q + SA_W'(MAX_LENGTH);
        state_d = (k_q + 1'b1 == stored_q) ? ST_LBL : ST_SETUP;
      end
      ST_LBL: begin
        // Label read of the best sequence is in flight.
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_label_d = fin_label;
          out_score_d = best_q;
          out_index_d = bestk_wide[INDEX_W-1:0];
          out_match_d = fin_match;
          out_full_d  = (stored_q >= CNT_W'(MAX_SEQUENCES));
          out_trunc_d = trunc_q;
          if (!fin_match) clus_d = new_label;
          if (stored_q < CNT_W'(MAX_SEQUENCES)) begin
            meta_we  = 1'b1;
            stored_d = stored_q + 1'b1;
            base_d   = base_q + SA_W'(MAX_LENGTH);
          end
          cur_len_d = '0;
          trunc_d   = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Shared lookup-and-add: accumulate the registered pair that pend_q marks.
    if (pend_q) sum_d = sum_q + SUM_W'(pair_value(cur_rd_q, seq_rd_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thresh_q    <= THRESH_RESET;
      cur_len_q   <= '0;
      trunc_q     <= 1'b0;
      stored_q    <= '0;
      base_q      <= '0;
      clus_q      <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) thresh_q <= cfg_wdata_i;
      cur_len_q   <= cur_len_d;
      trunc_q     <= trunc_d;
      stored_q    <= stored_d;
      base_q      <= base_d;
      clus_q      <= clus_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    kbase_q     <= kbase_d;
    n_q         <= n_d;
    i_q         <= i_d;
    sum_q       <= sum_d;
    best_q      <= best_d;
    bestk_q     <= bestk_d;
    out_label_q <= out_label_d;
    out_score_q <= out_score_d;
    out_index_q <= out_index_d;
    out_match_q <= out_match_d;
    out_full_q  <= out_full_d;
    out_trunc_q <= out_trunc_d;
  end

  // Memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (seq_we) seq_mem[seq_wa] <= in_i.residue;
    seq_rd_q <= seq_mem[kbase_q + SA_W'(i_q)];
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[eff_len[IW-1:0]] <= in_i.residue;
    cur_rd_q <= cur_mem[i_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) len_mem[stored_q[KW-1:0]] <= cur_len_q;
    len_rd_q <= len_mem[k_q[KW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) lbl_mem[stored_q[KW-1:0]] <= fin_label;
    lbl_rd_q <= lbl_mem[bestk_q[KW-1:0]];
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cluster_label = out_label_q;
  assign out_o.best_score    = out_score_q;
  assign out_o.best_index    = out_index_q;
  assign out_o.had_match     = out_match_q;
  assign out_o.store_full    = out_full_q;
  assign out_o.truncated     = out_trunc_q;

endmodule
